### rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the HSV to RGB converter
// Hue sector codes, hue boundaries and the reciprocal constants that turn
// the two fixed divisions (by 255 and by 60*255) into multiplications.
// ----------------------------------------------------------------------------
package h2r_pkg;

  localparam int unsigned HueW  = 9;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 6;   // sector fraction 0..60
  localparam int unsigned ProdW = 16;  // 8 x 8 products
  localparam int unsigned NumW  = 22;  // mid numerator, at most 60*255*255

  localparam logic [HueW-1:0] Hue60  = 9'd60;
  localparam logic [HueW-1:0] Hue120 = 9'd120;
  localparam logic [HueW-1:0] Hue180 = 9'd180;
  localparam logic [HueW-1:0] Hue240 = 9'd240;
  localparam logic [HueW-1:0] Hue300 = 9'd300;
  localparam logic [HueW-1:0] Hue360 = 9'd360;

  localparam logic [NumW-1:0] SpanMul = 22'd60;

  // floor(n / d) == (n * ceil(2^k / d)) >> k for n < 2^N, k = N + ceil(log2 d)
  localparam int unsigned LoDiv   = 255;
  localparam int unsigned LoShift = 24;  // N = 16, ceil(log2 255) = 8
  localparam int unsigned LoMagW  = 17;
  localparam logic [LoMagW-1:0] LoMagic =
    LoMagW'(((64'd1 << LoShift) + 64'(LoDiv) - 64'd1) / 64'(LoDiv));

  localparam int unsigned MidDiv   = 60 * 255;
  localparam int unsigned MidShift = 36;  // N = 22, ceil(log2 15300) = 14
  localparam int unsigned MidMagW  = 23;
  localparam logic [MidMagW-1:0] MidMagic =
    MidMagW'(((64'd1 << MidShift) + 64'(MidDiv) - 64'd1) / 64'(MidDiv));

  typedef enum logic [2:0] {
    SEC_RY    = 3'd0,  // red max, green rising
    SEC_YG    = 3'd1,  // green max, red falling
    SEC_GC    = 3'd2,  // green max, blue rising
    SEC_CB    = 3'd3,  // blue max, green falling
    SEC_BM    = 3'd4,  // blue max, red rising
    SEC_MR    = 3'd5,  // red max, blue falling
    SEC_BLACK = 3'd6   // hue out of range
  } sector_e;

endpackage

### rtl/h2r_const_div.sv
// ----------------------------------------------------------------------------
// h2r_const_div: registered divide-by-constant stage
// Divides the low-channel numerator by 255 and the mid-channel numerator by
// 60*255 through exact reciprocal multiplication, and registers both.
// ----------------------------------------------------------------------------
module h2r_const_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [h2r_pkg::ProdW-1:0]   lo_num_i,
  input  logic [h2r_pkg::NumW-1:0]    mid_num_i,
  output logic [h2r_pkg::ChanW-1:0]   lo_o,
  output logic [h2r_pkg::ChanW-1:0]   mid_o
);

  localparam int unsigned LoPW  = h2r_pkg::ProdW + h2r_pkg::LoMagW;
  localparam int unsigned MidPW = h2r_pkg::NumW + h2r_pkg::MidMagW;

  logic [LoPW-1:0]               lo_prod;
  logic [MidPW-1:0]              mid_prod;
  logic [h2r_pkg::ChanW-1:0]     lo_d, lo_q;
  logic [h2r_pkg::ChanW-1:0]     mid_d, mid_q;

  assign lo_prod  = LoPW'(lo_num_i) * LoPW'(h2r_pkg::LoMagic);
  assign mid_prod = MidPW'(mid_num_i) * MidPW'(h2r_pkg::MidMagic);

  // both quotients are known to stay within 0..255
  assign lo_d  = lo_prod[h2r_pkg::LoShift +: h2r_pkg::ChanW];
  assign mid_d = mid_prod[h2r_pkg::MidShift +: h2r_pkg::ChanW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= lo_d;
      mid_q <= mid_d;
    end
  end

  assign lo_o  = lo_q;
  assign mid_o = mid_q;

endmodule

### rtl/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top: pipelined HSV to RGB pixel converter
// Converts hue (degrees), saturation and value to 8-bit red, green, blue.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | request   | in_valid_i / in_ready_o  | hue_i, saturation_i, brightness_i
//  out     | result    | out_valid_o / out_ready_i| red_o, green_o, blue_o
//
//  One pixel per clock sustained while out_ready_i is held high.
//  The four stages: sector decode and 8x8 products, mid numerator (6x16
//  multiply and add), reciprocal multiply for the two constant divisions,
//  channel select into the output register.
//  Reset clears the valid bits only; no clearing pass, ready after reset.
//  Each stage advances when it is empty or the one after it advances, so a
//  stall at the output backs up stage by stage and bubbles get squeezed out.
//
module hsv_to_rgb_converter_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [8:0] hue_i,
  input  logic [7:0] saturation_i,
  input  logic [7:0] brightness_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  // --------------------------------------------------------------------------
  // Stage advance chain
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4_q || out_ready_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_ready_o = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick the 60-degree sector and its fraction, form s*v and
  // (255-s)*v. The latter is the numerator of the dark channel.
  // --------------------------------------------------------------------------
  h2r_pkg::sector_e                sec1_d, sec1_q;
  logic [h2r_pkg::HueW-1:0]        frac_full;
  logic [h2r_pkg::FracW-1:0]       frac1_q;
  logic [h2r_pkg::ChanW-1:0]       sat_inv1;
  logic [h2r_pkg::ProdW-1:0]       sv1_d, sv1_q;
  logic [h2r_pkg::ProdW-1:0]       dark1_d, dark1_q;
  logic [h2r_pkg::ChanW-1:0]       val1_q;

  always_comb begin
    sec1_d    = h2r_pkg::SEC_BLACK;
    frac_full = '0;
    if (hue_i < h2r_pkg::Hue60) begin
      sec1_d    = h2r_pkg::SEC_RY;
      frac_full = hue_i;
    end else if (hue_i < h2r_pkg::Hue120) begin
      sec1_d    = h2r_pkg::SEC_YG;
      frac_full = h2r_pkg::Hue120 - hue_i;
    end else if (hue_i < h2r_pkg::Hue180) begin
      sec1_d    = h2r_pkg::SEC_GC;
      frac_full = hue_i - h2r_pkg::Hue120;
    end else if (hue_i < h2r_pkg::Hue240) begin
      sec1_d    = h2r_pkg::SEC_CB;
      frac_full = h2r_pkg::Hue240 - hue_i;
    end else if (hue_i < h2r_pkg::Hue300) begin
      sec1_d    = h2r_pkg::SEC_BM;
      frac_full = hue_i - h2r_pkg::Hue240;
    end else if (hue_i <= h2r_pkg::Hue360) begin
      // hue of exactly 360 stays in the last sector with a fraction of zero
      sec1_d    = h2r_pkg::SEC_MR;
      frac_full = h2r_pkg::Hue360 - hue_i;
    end
  end

  // 255 - s is the bitwise complement of an 8-bit s
  assign sat_inv1 = ~saturation_i;

  assign sv1_d   = h2r_pkg::ProdW'(saturation_i) * h2r_pkg::ProdW'(brightness_i);
  assign dark1_d = h2r_pkg::ProdW'(sat_inv1) * h2r_pkg::ProdW'(brightness_i);

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      sec1_q  <= sec1_d;
      frac1_q <= frac_full[h2r_pkg::FracW-1:0];
      sv1_q   <= sv1_d;
      dark1_q <= dark1_d;
      val1_q  <= brightness_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: mid numerator f*s*v + 60*(255-s)*v
  // --------------------------------------------------------------------------
  logic [h2r_pkg::NumW-1:0]   mid_num2_d, mid_num2_q;
  h2r_pkg::sector_e           sec2_q;
  logic [h2r_pkg::ProdW-1:0]  dark2_q;
  logic [h2r_pkg::ChanW-1:0]  val2_q;

  assign mid_num2_d = h2r_pkg::NumW'(frac1_q) * h2r_pkg::NumW'(sv1_q)
                    + h2r_pkg::NumW'(dark1_q) * h2r_pkg::SpanMul;

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      mid_num2_q <= mid_num2_d;
      sec2_q     <= sec1_q;
      dark2_q    <= dark1_q;
      val2_q     <= val1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: both constant divisions
  // --------------------------------------------------------------------------
  logic [h2r_pkg::ChanW-1:0]  lo3, mid3;
  h2r_pkg::sector_e           sec3_q;
  logic [h2r_pkg::ChanW-1:0]  val3_q;

  h2r_const_div u_div (
    .clk_i     (clk_i),
    .en_i      (adv3 && v2_q),
    .lo_num_i  (dark2_q),
    .mid_num_i (mid_num2_q),
    .lo_o      (lo3),
    .mid_o     (mid3)
  );

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      sec3_q <= sec2_q;
      val3_q <= val2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: route bright, mid and dark onto the channels, hold on stall
  // --------------------------------------------------------------------------
  logic [h2r_pkg::ChanW-1:0] red_d, green_d, blue_d;
  logic [h2r_pkg::ChanW-1:0] red_q, green_q, blue_q;

  always_comb begin
    case (sec3_q)
      h2r_pkg::SEC_RY: begin
        red_d = val3_q; green_d = mid3;   blue_d = lo3;
      end
      h2r_pkg::SEC_YG: begin
        red_d = mid3;   green_d = val3_q; blue_d = lo3;
      end
      h2r_pkg::SEC_GC: begin
        red_d = lo3;    green_d = val3_q; blue_d = mid3;
      end
      h2r_pkg::SEC_CB: begin
        red_d = lo3;    green_d = mid3;   blue_d = val3_q;
      end
      h2r_pkg::SEC_BM: begin
        red_d = mid3;   green_d = lo3;    blue_d = val3_q;
      end
      h2r_pkg::SEC_MR: begin
        red_d = val3_q; green_d = lo3;    blue_d = mid3;
      end
      default: begin
        red_d = '0;     green_d = '0;     blue_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv4 && v3_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = v4_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef ASSERT_OFF
  // an empty output register never blocks the input
  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> in_ready_o
  ) else $error("input stalled with empty output register");

  // the interpolated channel lies between dark and bright
  a_mid_bounds: assert property (
    @(posedge clk_i) disable iff (!rst_ni) v3_q |-> (lo3 <= mid3) && (mid3 <= val3_q)
  ) else $error("mid channel outside dark..bright range");

  // out-of-range hue gives black
  a_black: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (v3_q && adv4 && sec3_q == h2r_pkg::SEC_BLACK)
      |=> (red_o == '0) && (green_o == '0) && (blue_o == '0)
  ) else $error("out-of-range hue did not give black");

  // in a valid sector one channel carries the value
  a_bright: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (v3_q && adv4 && sec3_q != h2r_pkg::SEC_BLACK)
      |=> (red_o == $past(val3_q)) || (green_o == $past(val3_q))
          || (blue_o == $past(val3_q))
  ) else $error("no channel equals the value");
`endif

endmodule
